/* sv/hsvrgb_pkg.sv */
package hsvrgb_pkg;

   // Width of every field on the request and response channels.
   localparam int FIELD_W = 16;

   // Default number of fraction bits: ONE = 2**FRAC_BITS stands for 1.0.
   localparam int FRAC_BITS_DEF = 15;

   typedef struct packed {
      logic [FIELD_W-1:0] hue;
      logic [FIELD_W-1:0] saturation;
      logic [FIELD_W-1:0] brightness;
   } hsv_word_type;

   typedef struct packed {
      logic [FIELD_W-1:0] red;
      logic [FIELD_W-1:0] green;
      logic [FIELD_W-1:0] blue;
   } rgb_word_type;

   // Colour-wheel sectors, named by the hues at their two ends.
   typedef enum logic [2:0] {
      SECTOR_RY = 3'd0,
      SECTOR_YG = 3'd1,
      SECTOR_GC = 3'd2,
      SECTOR_CB = 3'd3,
      SECTOR_BM = 3'd4,
      SECTOR_MR = 3'd5
   } sector_type;

endpackage

/* sv/hsv_to_rgb_converter_top.sv */
// HSV to RGB pixel converter.
// Request channel (req_valid, req_ready, req_word) carries one pixel per word:
// hue, saturation and brightness as unsigned fractions where 2**FRAC_BITS is
// 1.0; values above 1.0 are clamped to 1.0. The response channel (rsp_valid,
// rsp_ready, rsp_word) returns red, green and blue in the same format, one
// word per request, in order.
// The datapath is a four-stage pipeline: sector and fraction, the first
// products (s*f, s*(1-f), p), the second products (q, t), then the channel
// routing into the output register. A word accepted into the first stage
// passes each later stage before it shows on rsp_valid. A new word may be
// accepted every cycle while not frozen. The two chained multiplications
// are each given a stage. If rsp_ready is low with a word waiting, the whole
// pipeline freezes and req_ready falls; nothing is dropped or repeated.
// Reset clears every valid bit; the pipeline is then empty and ready.
module hsv_to_rgb_converter_top #(
   parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF,
   localparam int VAL_W = (FRAC_BITS < hsvrgb_pkg::FIELD_W) ? FRAC_BITS + 1
                                                            : hsvrgb_pkg::FIELD_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  hsvrgb_pkg::hsv_word_type req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output hsvrgb_pkg::rgb_word_type rsp_word
);

   logic advance;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   hsvrgb_pkg::sector_type s1_sector, s2_sector, s3_sector;
   logic [FRAC_BITS-1:0]   s1_frac;
   logic [VAL_W-1:0]       s1_sat, s1_val;
   logic [VAL_W-1:0]       s2_sf, s2_snf, s2_p, s2_val;
   logic [VAL_W-1:0]       s3_q, s3_t, s3_p, s3_val;

   // The pipeline moves as one whenever the output register is free or
   // being emptied.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      s1_valid_in  = advance ? req_valid   : s1_valid_ff;
      s2_valid_in  = advance ? s1_valid_ff : s2_valid_ff;
      s3_valid_in  = advance ? s2_valid_ff : s3_valid_ff;
      rsp_valid_in = advance ? s3_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   hsvrgb_sector #(.FRAC_BITS(FRAC_BITS)) u_sector (
      .clock     (clock),
      .advance   (advance),
      .req_word  (req_word),
      .sector_ff (s1_sector),
      .frac_ff   (s1_frac),
      .sat_ff    (s1_sat),
      .val_ff    (s1_val)
   );

   hsvrgb_frac #(.FRAC_BITS(FRAC_BITS)) u_frac (
      .clock     (clock),
      .advance   (advance),
      .sector    (s1_sector),
      .frac      (s1_frac),
      .sat       (s1_sat),
      .val       (s1_val),
      .sector_ff (s2_sector),
      .sf_ff     (s2_sf),
      .snf_ff    (s2_snf),
      .p_ff      (s2_p),
      .val_ff    (s2_val)
   );

   hsvrgb_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock     (clock),
      .advance   (advance),
      .sector    (s2_sector),
      .sf        (s2_sf),
      .snf       (s2_snf),
      .p         (s2_p),
      .val       (s2_val),
      .sector_ff (s3_sector),
      .q_ff      (s3_q),
      .t_ff      (s3_t),
      .p_ff      (s3_p),
      .val_ff    (s3_val)
   );

   hsvrgb_route #(.FRAC_BITS(FRAC_BITS)) u_route (
      .clock       (clock),
      .advance     (advance),
      .sector      (s3_sector),
      .q           (s3_q),
      .t           (s3_t),
      .p           (s3_p),
      .val         (s3_val),
      .rsp_word_ff (rsp_word)
   );

endmodule

/* sv/hsvrgb_sector.sv */
module hsvrgb_sector #(
   parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF,
   localparam int VAL_W = (FRAC_BITS < hsvrgb_pkg::FIELD_W) ? FRAC_BITS + 1
                                                            : hsvrgb_pkg::FIELD_W
) (
   input  logic                     clock,
   input  logic                     advance,
   input  hsvrgb_pkg::hsv_word_type req_word,
   output hsvrgb_pkg::sector_type   sector_ff,
   output logic [FRAC_BITS-1:0]     frac_ff,
   output logic [VAL_W-1:0]         sat_ff,
   output logic [VAL_W-1:0]         val_ff
);

   localparam int CMP_W = (FRAC_BITS + 1 > hsvrgb_pkg::FIELD_W) ? FRAC_BITS + 1
                                                                : hsvrgb_pkg::FIELD_W;
   localparam int H6_W  = FRAC_BITS + 3;
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   hsvrgb_pkg::sector_type sector_in;
   logic [FRAC_BITS-1:0]   frac_in;
   logic [VAL_W-1:0]       sat_in;
   logic [VAL_W-1:0]       val_in;
   logic [VAL_W-1:0]       hue_sat;
   logic [H6_W-1:0]        hue_ext;
   logic [H6_W-1:0]        hue6;
   logic [2:0]             sector_raw;

   // Clamp a field to the range 0 .. ONE.
   function automatic logic [VAL_W-1:0] clamp_one(input logic [hsvrgb_pkg::FIELD_W-1:0] x);
      logic over;
      over = CMP_W'(x) > CMP_W'(ONE);
      return over ? ONE[VAL_W-1:0] : x[VAL_W-1:0];
   endfunction

   always_comb begin
      hue_sat    = clamp_one(req_word.hue);
      sat_in     = clamp_one(req_word.saturation);
      val_in     = clamp_one(req_word.brightness);
      hue_ext    = H6_W'(hue_sat);
      hue6       = (hue_ext << 2) + (hue_ext << 1);
      sector_raw = hue6[H6_W-1:FRAC_BITS];
      frac_in    = hue6[FRAC_BITS-1:0];
      // A full-turn hue lands one past the last sector and wraps to the first.
      if (sector_raw > 3'(hsvrgb_pkg::SECTOR_MR)) begin
         sector_in = hsvrgb_pkg::SECTOR_RY;
      end else begin
         sector_in = hsvrgb_pkg::sector_type'(sector_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sector_ff <= sector_in;
         frac_ff   <= frac_in;
         sat_ff    <= sat_in;
         val_ff    <= val_in;
      end
   end

endmodule

/* sv/hsvrgb_frac.sv */
module hsvrgb_frac #(
   parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF,
   localparam int VAL_W = (FRAC_BITS < hsvrgb_pkg::FIELD_W) ? FRAC_BITS + 1
                                                            : hsvrgb_pkg::FIELD_W
) (
   input  logic                   clock,
   input  logic                   advance,
   input  hsvrgb_pkg::sector_type sector,
   input  logic [FRAC_BITS-1:0]   frac,
   input  logic [VAL_W-1:0]       sat,
   input  logic [VAL_W-1:0]       val,
   output hsvrgb_pkg::sector_type sector_ff,
   output logic [VAL_W-1:0]       sf_ff,
   output logic [VAL_W-1:0]       snf_ff,
   output logic [VAL_W-1:0]       p_ff,
   output logic [VAL_W-1:0]       val_ff
);

   localparam int PROD_W = VAL_W + FRAC_BITS + 1;
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic [FRAC_BITS:0] one_minus_f;
   logic [FRAC_BITS:0] one_minus_s;
   logic [PROD_W-1:0]  sf_prod;
   logic [PROD_W-1:0]  snf_prod;
   logic [PROD_W-1:0]  p_prod;

   always_comb begin
      one_minus_f = ONE - (FRAC_BITS + 1)'(frac);
      one_minus_s = ONE - (FRAC_BITS + 1)'(sat);
      sf_prod     = PROD_W'(sat) * PROD_W'(frac);
      snf_prod    = PROD_W'(sat) * PROD_W'(one_minus_f);
      p_prod      = PROD_W'(val) * PROD_W'(one_minus_s);
   end

   // Each product is at most its first factor, so VAL_W bits above the
   // fraction hold it whole.
   always_ff @(posedge clock) begin
      if (advance) begin
         sector_ff <= sector;
         sf_ff     <= sf_prod[VAL_W+FRAC_BITS-1:FRAC_BITS];
         snf_ff    <= snf_prod[VAL_W+FRAC_BITS-1:FRAC_BITS];
         p_ff      <= p_prod[VAL_W+FRAC_BITS-1:FRAC_BITS];
         val_ff    <= val;
      end
   end

endmodule

/* sv/hsvrgb_blend.sv */
module hsvrgb_blend #(
   parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF,
   localparam int VAL_W = (FRAC_BITS < hsvrgb_pkg::FIELD_W) ? FRAC_BITS + 1
                                                            : hsvrgb_pkg::FIELD_W
) (
   input  logic                   clock,
   input  logic                   advance,
   input  hsvrgb_pkg::sector_type sector,
   input  logic [VAL_W-1:0]       sf,
   input  logic [VAL_W-1:0]       snf,
   input  logic [VAL_W-1:0]       p,
   input  logic [VAL_W-1:0]       val,
   output hsvrgb_pkg::sector_type sector_ff,
   output logic [VAL_W-1:0]       q_ff,
   output logic [VAL_W-1:0]       t_ff,
   output logic [VAL_W-1:0]       p_ff,
   output logic [VAL_W-1:0]       val_ff
);

   localparam int PROD_W = VAL_W + FRAC_BITS + 1;
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic [FRAC_BITS:0] one_minus_sf;
   logic [FRAC_BITS:0] one_minus_snf;
   logic [PROD_W-1:0]  q_prod;
   logic [PROD_W-1:0]  t_prod;

   always_comb begin
      one_minus_sf  = ONE - (FRAC_BITS + 1)'(sf);
      one_minus_snf = ONE - (FRAC_BITS + 1)'(snf);
      q_prod        = PROD_W'(val) * PROD_W'(one_minus_sf);
      t_prod        = PROD_W'(val) * PROD_W'(one_minus_snf);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sector_ff <= sector;
         q_ff      <= q_prod[VAL_W+FRAC_BITS-1:FRAC_BITS];
         t_ff      <= t_prod[VAL_W+FRAC_BITS-1:FRAC_BITS];
         p_ff      <= p;
         val_ff    <= val;
      end
   end

endmodule

/* sv/hsvrgb_route.sv */
module hsvrgb_route #(
   parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF,
   localparam int VAL_W = (FRAC_BITS < hsvrgb_pkg::FIELD_W) ? FRAC_BITS + 1
                                                            : hsvrgb_pkg::FIELD_W
) (
   input  logic                     clock,
   input  logic                     advance,
   input  hsvrgb_pkg::sector_type   sector,
   input  logic [VAL_W-1:0]         q,
   input  logic [VAL_W-1:0]         t,
   input  logic [VAL_W-1:0]         p,
   input  logic [VAL_W-1:0]         val,
   output hsvrgb_pkg::rgb_word_type rsp_word_ff
);

   logic [VAL_W-1:0]         red;
   logic [VAL_W-1:0]         green;
   logic [VAL_W-1:0]         blue;
   hsvrgb_pkg::rgb_word_type rsp_word_in;

   always_comb begin
      case (sector)
         hsvrgb_pkg::SECTOR_RY: begin
            red = val; green = t;   blue = p;
         end
         hsvrgb_pkg::SECTOR_YG: begin
            red = q;   green = val; blue = p;
         end
         hsvrgb_pkg::SECTOR_GC: begin
            red = p;   green = val; blue = t;
         end
         hsvrgb_pkg::SECTOR_CB: begin
            red = p;   green = q;   blue = val;
         end
         hsvrgb_pkg::SECTOR_BM: begin
            red = t;   green = p;   blue = val;
         end
         default: begin
            red = val; green = p;   blue = q;
         end
      endcase
      rsp_word_in.red   = hsvrgb_pkg::FIELD_W'(red);
      rsp_word_in.green = hsvrgb_pkg::FIELD_W'(green);
      rsp_word_in.blue  = hsvrgb_pkg::FIELD_W'(blue);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule
